// ----- src/rvr4_pkg.sv -----
package rvr4_pkg;

    // Field formats
    localparam int ROT_W     = 18;               // Q1.16 rotor parts
    localparam int VEC_W     = 24;               // Q8.16 vector parts
    localparam int PRD_W     = 2 * ROT_W;        // rotor pair product, 2^-32
    localparam int MAT_W     = PRD_W + 2;        // rotation matrix entry
    localparam int MPRD_W    = MAT_W + VEC_W;    // matrix entry times component, 2^-48
    localparam int ACC_W     = MPRD_W + 2;       // row sum of four products
    localparam int OUT_SHIFT = 32;               // 2^-48 -> 2^-16
    localparam int Q_W       = ACC_W - OUT_SHIFT;
    localparam int DIMS      = 4;

    typedef logic signed [ROT_W-1:0]  t_rot;
    typedef logic signed [VEC_W-1:0]  t_vec;
    typedef logic signed [PRD_W-1:0]  t_prd;
    typedef logic signed [MAT_W-1:0]  t_mat;
    typedef logic signed [MPRD_W-1:0] t_mprd;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [Q_W-1:0]    t_q;

    localparam t_vec VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
    localparam t_vec VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

    // All pairwise rotor products the rotation matrix needs
    typedef struct packed {
        t_prd rr;
        t_prd aa;
        t_prd bb;
        t_prd cc;
        t_prd dd;
        t_prd ee;
        t_prd ff;
        t_prd ra;
        t_prd rb;
        t_prd rc;
        t_prd rd;
        t_prd re;
        t_prd rf;
        t_prd ab;
        t_prd ac;
        t_prd ad;
        t_prd ae;
        t_prd bc;
        t_prd bd;
        t_prd bf;
        t_prd ce;
        t_prd cf;
        t_prd de;
        t_prd df;
        t_prd ef;
    } t_prods;

endpackage

// ----- src/rvr4_if.sv -----
// Rotor plus vector transaction
interface rvr4_in_if;
    logic              valid;
    logic              ready;
    rvr4_pkg::t_rot    rotor_scalar;
    rvr4_pkg::t_rot    rotor_xy;
    rvr4_pkg::t_rot    rotor_xz;
    rvr4_pkg::t_rot    rotor_xw;
    rvr4_pkg::t_rot    rotor_yz;
    rvr4_pkg::t_rot    rotor_yw;
    rvr4_pkg::t_rot    rotor_zw;
    rvr4_pkg::t_vec    vec_x;
    rvr4_pkg::t_vec    vec_y;
    rvr4_pkg::t_vec    vec_z;
    rvr4_pkg::t_vec    vec_w;

    modport source (
        output valid, rotor_scalar, rotor_xy, rotor_xz, rotor_xw,
               rotor_yz, rotor_yw, rotor_zw, vec_x, vec_y, vec_z, vec_w,
        input  ready
    );
    modport sink (
        input  valid, rotor_scalar, rotor_xy, rotor_xz, rotor_xw,
               rotor_yz, rotor_yw, rotor_zw, vec_x, vec_y, vec_z, vec_w,
        output ready
    );
endinterface

// Rotated vector transaction
interface rvr4_out_if;
    logic              valid;
    logic              ready;
    rvr4_pkg::t_vec    out_x;
    rvr4_pkg::t_vec    out_y;
    rvr4_pkg::t_vec    out_z;
    rvr4_pkg::t_vec    out_w;
    logic              saturated;

    modport source (
        output valid, out_x, out_y, out_z, out_w, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, out_w, saturated,
        output ready
    );
endinterface

// ----- src/rotor_vector_rotate_4d.sv -----
// Rotates a 4D vector (Q8.16) by a rotor given as scalar plus six bivector
// parts (Q1.16), out = R v conj(R), rounded half up to Q8.16 and saturated;
// saturated is set when any component was clipped. The rotor is not
// normalized, so the result scales with its squared length. Five-stage
// pipeline: rotor pair products, 4x4 rotation matrix, sixteen matrix-times-
// component products (38x24 bits), row sums, round and clip. A new
// transaction is accepted every cycle while the output side takes results.
// Each stage holds its item under backpressure and fills bubbles, so a
// stalled output only blocks input once every stage holds an item.
module rotor_vector_rotate_4d (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rvr4_in_if.sink     i_in,
    rvr4_out_if.source  o_out
);

    localparam int NSTG = 5;
    localparam rvr4_pkg::t_acc RND_HALF = rvr4_pkg::t_acc'(1) <<< (rvr4_pkg::OUT_SHIFT - 1);

    function automatic rvr4_pkg::t_prd mul(rvr4_pkg::t_rot p1, rvr4_pkg::t_rot p2);
        return rvr4_pkg::t_prd'(p1) * rvr4_pkg::t_prd'(p2);
    endfunction

    function automatic rvr4_pkg::t_mat ext(rvr4_pkg::t_prd p);
        return rvr4_pkg::t_mat'(p);
    endfunction

    function automatic rvr4_pkg::t_mat dbl(rvr4_pkg::t_prd p1, rvr4_pkg::t_prd p2,
                                           rvr4_pkg::t_prd p3, logic s2, logic s3);
        rvr4_pkg::t_mat s;
        s = ext(p1);
        s = s2 ? s - ext(p2) : s + ext(p2);
        s = s3 ? s - ext(p3) : s + ext(p3);
        return s <<< 1;
    endfunction

    // Stage valids and per-stage advance
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_in.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: rotor pair products
    rvr4_pkg::t_prods r_p, n_p;
    rvr4_pkg::t_vec   r_vec1 [rvr4_pkg::DIMS];

    always_comb begin
        n_p.rr = mul(i_in.rotor_scalar, i_in.rotor_scalar);
        n_p.aa = mul(i_in.rotor_xy, i_in.rotor_xy);
        n_p.bb = mul(i_in.rotor_xz, i_in.rotor_xz);
        n_p.cc = mul(i_in.rotor_xw, i_in.rotor_xw);
        n_p.dd = mul(i_in.rotor_yz, i_in.rotor_yz);
        n_p.ee = mul(i_in.rotor_yw, i_in.rotor_yw);
        n_p.ff = mul(i_in.rotor_zw, i_in.rotor_zw);
        n_p.ra = mul(i_in.rotor_scalar, i_in.rotor_xy);
        n_p.rb = mul(i_in.rotor_scalar, i_in.rotor_xz);
        n_p.rc = mul(i_in.rotor_scalar, i_in.rotor_xw);
        n_p.rd = mul(i_in.rotor_scalar, i_in.rotor_yz);
        n_p.re = mul(i_in.rotor_scalar, i_in.rotor_yw);
        n_p.rf = mul(i_in.rotor_scalar, i_in.rotor_zw);
        n_p.ab = mul(i_in.rotor_xy, i_in.rotor_xz);
        n_p.ac = mul(i_in.rotor_xy, i_in.rotor_xw);
        n_p.ad = mul(i_in.rotor_xy, i_in.rotor_yz);
        n_p.ae = mul(i_in.rotor_xy, i_in.rotor_yw);
        n_p.bc = mul(i_in.rotor_xz, i_in.rotor_xw);
        n_p.bd = mul(i_in.rotor_xz, i_in.rotor_yz);
        n_p.bf = mul(i_in.rotor_xz, i_in.rotor_zw);
        n_p.ce = mul(i_in.rotor_xw, i_in.rotor_yw);
        n_p.cf = mul(i_in.rotor_xw, i_in.rotor_zw);
        n_p.de = mul(i_in.rotor_yz, i_in.rotor_yw);
        n_p.df = mul(i_in.rotor_yz, i_in.rotor_zw);
        n_p.ef = mul(i_in.rotor_yw, i_in.rotor_zw);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_p       <= n_p;
            r_vec1[0] <= i_in.vec_x;
            r_vec1[1] <= i_in.vec_y;
            r_vec1[2] <= i_in.vec_z;
            r_vec1[3] <= i_in.vec_w;
        end
    end

    // Stage 2: rotation matrix, rr*I + 2r*[B] - (B v B coefficients)
    rvr4_pkg::t_mat r_m [rvr4_pkg::DIMS][rvr4_pkg::DIMS];
    rvr4_pkg::t_mat n_m [rvr4_pkg::DIMS][rvr4_pkg::DIMS];
    rvr4_pkg::t_vec r_vec2 [rvr4_pkg::DIMS];

    always_comb begin
        n_m[0][0] = ext(r_p.rr) - ext(r_p.aa) - ext(r_p.bb) - ext(r_p.cc)
                  + ext(r_p.dd) + ext(r_p.ee) + ext(r_p.ff);
        n_m[1][1] = ext(r_p.rr) - ext(r_p.aa) - ext(r_p.dd) - ext(r_p.ee)
                  + ext(r_p.bb) + ext(r_p.cc) + ext(r_p.ff);
        n_m[2][2] = ext(r_p.rr) - ext(r_p.bb) - ext(r_p.dd) - ext(r_p.ff)
                  + ext(r_p.aa) + ext(r_p.cc) + ext(r_p.ee);
        n_m[3][3] = ext(r_p.rr) - ext(r_p.cc) - ext(r_p.ee) - ext(r_p.ff)
                  + ext(r_p.aa) + ext(r_p.bb) + ext(r_p.dd);
        // off-diagonal entries are all doubled sums of three products
        n_m[0][1] = -dbl(r_p.ra, r_p.bd, r_p.ce, 1'b0, 1'b0);
        n_m[0][2] = -dbl(r_p.rb, r_p.ad, r_p.cf, 1'b1, 1'b0);
        n_m[0][3] = -dbl(r_p.rc, r_p.ae, r_p.bf, 1'b1, 1'b1);
        n_m[1][0] =  dbl(r_p.ra, r_p.bd, r_p.ce, 1'b1, 1'b1);
        n_m[1][2] = -dbl(r_p.rd, r_p.ab, r_p.ef, 1'b0, 1'b0);
        n_m[1][3] = -dbl(r_p.re, r_p.ac, r_p.df, 1'b0, 1'b1);
        n_m[2][0] =  dbl(r_p.rb, r_p.ad, r_p.cf, 1'b0, 1'b1);
        n_m[2][1] =  dbl(r_p.rd, r_p.ab, r_p.ef, 1'b1, 1'b1);
        n_m[2][3] = -dbl(r_p.rf, r_p.bc, r_p.de, 1'b0, 1'b0);
        n_m[3][0] =  dbl(r_p.rc, r_p.ae, r_p.bf, 1'b0, 1'b0);
        n_m[3][1] =  dbl(r_p.re, r_p.ac, r_p.df, 1'b1, 1'b0);
        n_m[3][2] =  dbl(r_p.rf, r_p.bc, r_p.de, 1'b1, 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_m    <= n_m;
            r_vec2 <= r_vec1;
        end
    end

    // Stage 3: matrix entry times vector component
    rvr4_pkg::t_mprd r_mv [rvr4_pkg::DIMS][rvr4_pkg::DIMS];
    rvr4_pkg::t_mprd n_mv [rvr4_pkg::DIMS][rvr4_pkg::DIMS];

    always_comb begin
        for (int i = 0; i < rvr4_pkg::DIMS; i++) begin
            for (int j = 0; j < rvr4_pkg::DIMS; j++) begin
                n_mv[i][j] = rvr4_pkg::t_mprd'(r_m[i][j]) * rvr4_pkg::t_mprd'(r_vec2[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_mv <= n_mv;
        end
    end

    // Stage 4: row sums at scale 2^-48
    rvr4_pkg::t_acc r_acc [rvr4_pkg::DIMS];
    rvr4_pkg::t_acc n_acc [rvr4_pkg::DIMS];

    always_comb begin
        for (int i = 0; i < rvr4_pkg::DIMS; i++) begin
            n_acc[i] = rvr4_pkg::t_acc'(r_mv[i][0]) + rvr4_pkg::t_acc'(r_mv[i][1])
                     + rvr4_pkg::t_acc'(r_mv[i][2]) + rvr4_pkg::t_acc'(r_mv[i][3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_acc <= n_acc;
        end
    end

    // Stage 5: round half up to Q8.16 and clip
    rvr4_pkg::t_vec r_out [rvr4_pkg::DIMS];
    rvr4_pkg::t_vec n_out [rvr4_pkg::DIMS];
    logic           r_sat, n_sat;
    rvr4_pkg::t_acc rnd   [rvr4_pkg::DIMS];
    rvr4_pkg::t_q   q     [rvr4_pkg::DIMS];

    always_comb begin
        n_sat = 1'b0;
        for (int i = 0; i < rvr4_pkg::DIMS; i++) begin
            rnd[i] = r_acc[i] + RND_HALF;
            q[i]   = $signed(rnd[i][rvr4_pkg::ACC_W-1:rvr4_pkg::OUT_SHIFT]);
            if (q[i] > rvr4_pkg::t_q'(rvr4_pkg::VEC_MAX)) begin
                n_out[i] = rvr4_pkg::VEC_MAX;
                n_sat    = 1'b1;
            end else if (q[i] < rvr4_pkg::t_q'(rvr4_pkg::VEC_MIN)) begin
                n_out[i] = rvr4_pkg::VEC_MIN;
                n_sat    = 1'b1;
            end else begin
                n_out[i] = q[i][rvr4_pkg::VEC_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_out <= n_out;
            r_sat <= n_sat;
        end
    end

    assign o_out.valid     = r_v[NSTG-1];
    assign o_out.out_x     = r_out[0];
    assign o_out.out_y     = r_out[1];
    assign o_out.out_z     = r_out[2];
    assign o_out.out_w     = r_out[3];
    assign o_out.saturated = r_sat;

endmodule

// ----- src/rvr4_checker.sv -----
module rvr4_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input rvr4_pkg::t_vec i_out_x,
    input rvr4_pkg::t_vec i_out_y,
    input rvr4_pkg::t_vec i_out_z,
    input rvr4_pkg::t_vec i_out_w,
    input logic           i_out_sat
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_x) && $stable(i_out_y)
            && $stable(i_out_z) && $stable(i_out_w) && $stable(i_out_sat))
        else $error("stalled result changed");

    // Saturation flag means some component sits at a format limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_sat |->
            i_out_x == rvr4_pkg::VEC_MAX || i_out_x == rvr4_pkg::VEC_MIN
            || i_out_y == rvr4_pkg::VEC_MAX || i_out_y == rvr4_pkg::VEC_MIN
            || i_out_z == rvr4_pkg::VEC_MAX || i_out_z == rvr4_pkg::VEC_MIN
            || i_out_w == rvr4_pkg::VEC_MAX || i_out_w == rvr4_pkg::VEC_MIN)
        else $error("saturated without clipped component");

    // An open output path never blocks the input
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output ready");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind rotor_vector_rotate_4d rvr4_checker u_rvr4_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_x     (o_out.out_x),
    .i_out_y     (o_out.out_y),
    .i_out_z     (o_out.out_z),
    .i_out_w     (o_out.out_w),
    .i_out_sat   (o_out.saturated)
);

// ----- tb/sv/tb_rotor_vector_rotate_4d.sv -----
`timescale 1ns / 1ps

// One rotor plus vector transaction
typedef struct {
    rvr4_pkg::t_rot rotor_scalar;
    rvr4_pkg::t_rot rotor_xy;
    rvr4_pkg::t_rot rotor_xz;
    rvr4_pkg::t_rot rotor_xw;
    rvr4_pkg::t_rot rotor_yz;
    rvr4_pkg::t_rot rotor_yw;
    rvr4_pkg::t_rot rotor_zw;
    rvr4_pkg::t_vec vec_x;
    rvr4_pkg::t_vec vec_y;
    rvr4_pkg::t_vec vec_z;
    rvr4_pkg::t_vec vec_w;
} t_rotation_req;

// One rotated vector transaction
typedef struct {
    rvr4_pkg::t_vec out_x;
    rvr4_pkg::t_vec out_y;
    rvr4_pkg::t_vec out_z;
    rvr4_pkg::t_vec out_w;
    logic           saturated;
} t_rotated_vec;

class rotation_scoreboard;
    t_rotated_vec expected_rotations[$];
    int           mismatches = 0;

    // Round a 2^-48 sum half up to Q8.16 and clip to the vector range
    static function rvr4_pkg::t_vec round_clip(input longint acc, inout logic sat);
        longint q;
        q = (acc + 64'sd2147483648) >>> 32;
        if (q > longint'(rvr4_pkg::VEC_MAX)) begin
            sat = 1'b1;
            return rvr4_pkg::VEC_MAX;
        end
        if (q < longint'(rvr4_pkg::VEC_MIN)) begin
            sat = 1'b1;
            return rvr4_pkg::VEC_MIN;
        end
        return rvr4_pkg::t_vec'(q);
    endfunction

    // Sandwich product R v conj(R) in exact 64-bit integer arithmetic
    static function t_rotated_vec rotate_4d(input t_rotation_req req);
        longint       r, a, b, c, d, e, f, x, y, z, w;
        longint       rr, aa, bb, cc, dd, ee, ff, r2;
        longint       px, py, pz, pw, qx, qy, qz, qw;
        logic         sat;
        t_rotated_vec res;
        r = longint'(req.rotor_scalar);
        a = longint'(req.rotor_xy);
        b = longint'(req.rotor_xz);
        c = longint'(req.rotor_xw);
        d = longint'(req.rotor_yz);
        e = longint'(req.rotor_yw);
        f = longint'(req.rotor_zw);
        x = longint'(req.vec_x);
        y = longint'(req.vec_y);
        z = longint'(req.vec_z);
        w = longint'(req.vec_w);
        rr = r * r;
        aa = a * a; bb = b * b; cc = c * c;
        dd = d * d; ee = e * e; ff = f * f;
        // vector grade of bivector times vector
        px = -a * y - b * z - c * w;
        py = a * x - d * z - e * w;
        pz = b * x + d * y - f * w;
        pw = c * x + e * y + f * z;
        // bivector * vector * bivector
        qx = x * (aa + bb + cc - dd - ee - ff)
            + 2 * a * (-d * z - e * w)
            + 2 * b * (d * y - f * w)
            + 2 * c * (f * z + e * y);
        qy = y * (aa + dd + ee - bb - cc - ff)
            + 2 * a * (b * z + c * w)
            + 2 * d * (b * x - f * w)
            + 2 * e * (c * x + f * z);
        qz = z * (bb + dd + ff - aa - cc - ee)
            + 2 * b * (a * y + c * w)
            + 2 * d * (-a * x + e * w)
            + 2 * f * (c * x + e * y);
        qw = w * (cc + ee + ff - aa - bb - dd)
            + 2 * c * (a * y + b * z)
            + 2 * e * (-a * x + d * z)
            + 2 * f * (-b * x - d * y);
        r2  = 2 * r;
        sat = 1'b0;
        res.out_x = round_clip(rr * x + r2 * px - qx, sat);
        res.out_y = round_clip(rr * y + r2 * py - qy, sat);
        res.out_z = round_clip(rr * z + r2 * pz - qz, sat);
        res.out_w = round_clip(rr * w + r2 * pw - qw, sat);
        res.saturated = sat;
        return res;
    endfunction

    function void log_rotation_request(input t_rotation_req req);
        expected_rotations.push_back(rotate_4d(req));
    endfunction

    function void check_component(input string name, input rvr4_pkg::t_vec exp_v,
                                  input rvr4_pkg::t_vec got_v);
        if (got_v !== exp_v) begin
            mismatches++;
            $display("%0t %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
        end
    endfunction

    function void check_rotated_vector(input t_rotated_vec got);
        t_rotated_vec exp_r;
        if (expected_rotations.size() == 0) begin
            mismatches++;
            $display("%0t unexpected result: expected none, got (%0d %0d %0d %0d sat %0b)",
                     $time, got.out_x, got.out_y, got.out_z, got.out_w, got.saturated);
            return;
        end
        exp_r = expected_rotations.pop_front();
        check_component("out_x", exp_r.out_x, got.out_x);
        check_component("out_y", exp_r.out_y, got.out_y);
        check_component("out_z", exp_r.out_z, got.out_z);
        check_component("out_w", exp_r.out_w, got.out_w);
        if (got.saturated !== exp_r.saturated) begin
            mismatches++;
            $display("%0t saturated mismatch: expected %0b, got %0b",
                     $time, exp_r.saturated, got.saturated);
        end
    endfunction

    function int pending();
        return expected_rotations.size();
    endfunction
endclass

module tb_rotor_vector_rotate_4d;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int NUM_PHASES     = 4;
    localparam int HOLD_OFF_LEN   = 60;
    localparam int TAIL_CYCLES    = 10;
    localparam int ONE            = 65536;     // 1.0 in Q1.16 / Q8.16

    logic i_clk = 1'b0;
    logic i_rst_n;

    rvr4_in_if  rot_in ();
    rvr4_out_if rot_out ();

    rotor_vector_rotate_4d dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (rot_in),
        .o_out   (rot_out)
    );

    rotation_scoreboard sb = new();

    int send_idle_pct     = 0;
    int recv_stall_pct    = 0;
    int hold_off_request  = 0;
    int cycle_count       = 0;

    always #5 i_clk = ~i_clk;

    // Timeout watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("[rotor_vector_rotate_4d] ERROR");
            $finish;
        end
    end

    // Monitor both channels at the rising edge
    always @(posedge i_clk) begin
        t_rotation_req req;
        t_rotated_vec  got;
        if (i_rst_n) begin
            if (rot_in.valid && rot_in.ready) begin
                req.rotor_scalar = rot_in.rotor_scalar;
                req.rotor_xy     = rot_in.rotor_xy;
                req.rotor_xz     = rot_in.rotor_xz;
                req.rotor_xw     = rot_in.rotor_xw;
                req.rotor_yz     = rot_in.rotor_yz;
                req.rotor_yw     = rot_in.rotor_yw;
                req.rotor_zw     = rot_in.rotor_zw;
                req.vec_x        = rot_in.vec_x;
                req.vec_y        = rot_in.vec_y;
                req.vec_z        = rot_in.vec_z;
                req.vec_w        = rot_in.vec_w;
                sb.log_rotation_request(req);
            end
            if (rot_out.valid && rot_out.ready) begin
                got.out_x     = rot_out.out_x;
                got.out_y     = rot_out.out_y;
                got.out_z     = rot_out.out_z;
                got.out_w     = rot_out.out_w;
                got.saturated = rot_out.saturated;
                sb.check_rotated_vector(got);
            end
        end
    end

    // Result side: random stalls plus an occasional long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        rot_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request > 0) begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rot_out.ready <= 1'b0;
            end else begin
                rot_out.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic t_rotation_req make_req(input int r, input int a, input int b,
                                               input int c, input int d, input int e,
                                               input int f, input int x, input int y,
                                               input int z, input int w);
        t_rotation_req req;
        req.rotor_scalar = rvr4_pkg::t_rot'(r);
        req.rotor_xy     = rvr4_pkg::t_rot'(a);
        req.rotor_xz     = rvr4_pkg::t_rot'(b);
        req.rotor_xw     = rvr4_pkg::t_rot'(c);
        req.rotor_yz     = rvr4_pkg::t_rot'(d);
        req.rotor_yw     = rvr4_pkg::t_rot'(e);
        req.rotor_zw     = rvr4_pkg::t_rot'(f);
        req.vec_x        = rvr4_pkg::t_vec'(x);
        req.vec_y        = rvr4_pkg::t_vec'(y);
        req.vec_z        = rvr4_pkg::t_vec'(z);
        req.vec_w        = rvr4_pkg::t_vec'(w);
        return req;
    endfunction

    // Mix of small rotors (parts within +-0.5), single-plane rotors and raw full-range patterns
    function automatic t_rotation_req random_rotation_req();
        t_rotation_req  req;
        int unsigned    mode;
        rvr4_pkg::t_rot plane_val;
        mode = $urandom_range(9);
        req = make_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom);
        if (mode < 4) begin
            req.rotor_scalar = rvr4_pkg::t_rot'(int'($urandom_range(65535)) - 32768);
            req.rotor_xy     = rvr4_pkg::t_rot'(int'($urandom_range(65535)) - 32768);
            req.rotor_xz     = rvr4_pkg::t_rot'(int'($urandom_range(65535)) - 32768);
            req.rotor_xw     = rvr4_pkg::t_rot'(int'($urandom_range(65535)) - 32768);
            req.rotor_yz     = rvr4_pkg::t_rot'(int'($urandom_range(65535)) - 32768);
            req.rotor_yw     = rvr4_pkg::t_rot'(int'($urandom_range(65535)) - 32768);
            req.rotor_zw     = rvr4_pkg::t_rot'(int'($urandom_range(65535)) - 32768);
            if ($urandom_range(1) == 1) begin
                req.vec_x = rvr4_pkg::t_vec'(int'($urandom_range(2097151)) - 1048576);
                req.vec_y = rvr4_pkg::t_vec'(int'($urandom_range(2097151)) - 1048576);
                req.vec_z = rvr4_pkg::t_vec'(int'($urandom_range(2097151)) - 1048576);
                req.vec_w = rvr4_pkg::t_vec'(int'($urandom_range(2097151)) - 1048576);
            end
        end else if (mode < 7) begin
            // rotation in one plane only
            plane_val = rvr4_pkg::t_rot'(int'($urandom_range(131071)) - 65536);
            req.rotor_scalar = rvr4_pkg::t_rot'(int'($urandom_range(131071)) - 65536);
            req.rotor_xy = '0;
            req.rotor_xz = '0;
            req.rotor_xw = '0;
            req.rotor_yz = '0;
            req.rotor_yw = '0;
            req.rotor_zw = '0;
            case ($urandom_range(5))
                0: req.rotor_xy = plane_val;
                1: req.rotor_xz = plane_val;
                2: req.rotor_xw = plane_val;
                3: req.rotor_yz = plane_val;
                4: req.rotor_yw = plane_val;
                default: req.rotor_zw = plane_val;
            endcase
        end
        return req;
    endfunction

    // Offer one transaction; called and returns at a falling edge
    task automatic send_rotation(input t_rotation_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            rot_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        rot_in.rotor_scalar <= req.rotor_scalar;
        rot_in.rotor_xy     <= req.rotor_xy;
        rot_in.rotor_xz     <= req.rotor_xz;
        rot_in.rotor_xw     <= req.rotor_xw;
        rot_in.rotor_yz     <= req.rotor_yz;
        rot_in.rotor_yw     <= req.rotor_yw;
        rot_in.rotor_zw     <= req.rotor_zw;
        rot_in.vec_x        <= req.vec_x;
        rot_in.vec_y        <= req.vec_y;
        rot_in.vec_z        <= req.vec_z;
        rot_in.vec_w        <= req.vec_w;
        rot_in.valid        <= 1'b1;
        do @(posedge i_clk); while (!rot_in.ready);
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every outstanding rotation
    task automatic wait_all_rotated();
        rot_in.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_rotation_req directed[$];
        int            phase;
        i_rst_n = 1'b0;
        rot_in.valid = 1'b0;
        rot_in.rotor_scalar = '0;
        rot_in.rotor_xy = '0;
        rot_in.rotor_xz = '0;
        rot_in.rotor_xw = '0;
        rot_in.rotor_yz = '0;
        rot_in.rotor_yw = '0;
        rot_in.rotor_zw = '0;
        rot_in.vec_x = '0;
        rot_in.vec_y = '0;
        rot_in.vec_z = '0;
        rot_in.vec_w = '0;

        // zero rotor, identity rotor, extreme scalars
        directed.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 8388607, -8388608, 1, -1));
        directed.push_back(make_req(ONE, 0, 0, 0, 0, 0, 0, 1, -1, 8388607, -8388608));
        directed.push_back(make_req(ONE, 0, 0, 0, 0, 0, 0,
                                    8388607, 8388607, 8388607, 8388607));
        directed.push_back(make_req(-131072, 0, 0, 0, 0, 0, 0,
                                    8388607, -8388608, 100, -100));
        directed.push_back(make_req(131071, 0, 0, 0, 0, 0, 0,
                                    -8388608, -8388608, -8388608, -8388608));
        // each bivector plane alone at 1.0
        directed.push_back(make_req(0, ONE, 0, 0, 0, 0, 0, 1000, 2000, 3000, 4000));
        directed.push_back(make_req(0, 0, ONE, 0, 0, 0, 0, 1000, 2000, 3000, 4000));
        directed.push_back(make_req(0, 0, 0, ONE, 0, 0, 0, 1000, 2000, 3000, 4000));
        directed.push_back(make_req(0, 0, 0, 0, ONE, 0, 0, 1000, 2000, 3000, 4000));
        directed.push_back(make_req(0, 0, 0, 0, 0, ONE, 0, 1000, 2000, 3000, 4000));
        directed.push_back(make_req(0, 0, 0, 0, 0, 0, ONE, 1000, 2000, 3000, 4000));
        // quarter turn in the xy plane, then a mixed double rotation
        directed.push_back(make_req(46341, 46341, 0, 0, 0, 0, 0, ONE, 0, 0, 0));
        directed.push_back(make_req(32768, 32768, -32768, 0, 0, 0, 32768,
                                    ONE, -2 * ONE, 3 * ONE, -4 * ONE));
        // all rotor parts at one extreme, vector at the other, then alternating extremes
        directed.push_back(make_req(-131072, -131072, -131072, -131072, -131072, -131072,
                                    -131072, 8388607, 8388607, 8388607, 8388607));
        directed.push_back(make_req(131071, 131071, 131071, 131071, 131071, 131071,
                                    131071, -8388608, -8388608, -8388608, -8388608));
        directed.push_back(make_req(131071, -131072, 131071, -131072, 131071, -131072,
                                    131071, -8388608, 8388607, -8388608, 8388607));
        // large rotor times zero vector
        directed.push_back(make_req(-131072, 131071, -131072, 131071, -131072, 131071,
                                    -131072, 0, 0, 0, 0));
        // exact half steps: rounds up for positive and toward zero for negative
        directed.push_back(make_req(256, 0, 0, 0, 0, 0, 0, 32768, -32768, 32767, -32769));
        directed.push_back(make_req(256, 0, 0, 0, 0, 0, 0, 98304, -98304, 1, -1));
        // all-ones bit patterns
        directed.push_back(make_req(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) send_rotation(directed[i]);
        wait_all_rotated();

        // random phases with different idle and stall mixes
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            // long output hold-off so the pipeline fills and input stalls
            if (phase == 0 || phase == 3) hold_off_request = HOLD_OFF_LEN;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) send_rotation(random_rotation_req());
            wait_all_rotated();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[rotor_vector_rotate_4d] OK");
        end else begin
            $display("[rotor_vector_rotate_4d] ERROR");
        end
        $finish;
    end

endmodule
